/* design/nco_pkg.sv */
// Shared constants, arctangent table and status type for the sine oscillator.
package nco_pkg;

    // Default parameter values
    localparam int PHASE_BITS_DEF   = 32;
    localparam int OUT_BITS_DEF     = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed field and datapath widths
    localparam int FREQ_W       = 32;   // input increment width
    localparam int TURN_W       = 32;   // angle fed to the CORDIC
    localparam int ATAN_ENTRIES = 24;
    localparam int STEP_W       = 5;    // indexes the arctangent table
    localparam int XY_W         = 34;   // Q2.30 with headroom
    localparam int Z_W          = 33;   // signed turn fraction with headroom

    // CORDIC gain correction, 0.60725293500888 in Q2.30
    localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);

    // Core handshake status toward the top level
    typedef struct packed {
        logic ready;    // core can take a new angle
        logic done;     // sample is available
    } t_core_stat;

    // round(atan(2^-i) / (2 pi) * 2^32)
    function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [TURN_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/nco_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then round and clamp.
module nco_cordic
    import nco_pkg::*;
#(
    parameter int OUT_BITS     = OUT_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [TURN_W-1:0]          i_theta,
    input  logic                       i_take,
    output t_core_stat                 o_stat,
    output logic signed [OUT_BITS-1:0] o_sample
);

    localparam int STEPS  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int RND_SH = 31 - OUT_BITS;
    localparam int RND_W  = XY_W + 1;
    localparam logic signed [RND_W-1:0] HALF    = RND_W'(1) <<< (RND_SH - 1);
    localparam logic signed [RND_W-1:0] LIM     = RND_W'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [RND_W-1:0] NEG_LIM = -LIM;
    localparam logic [STEP_W-1:0]       LAST    = STEP_W'(STEPS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [STEP_W-1:0]       r_cnt;
    logic signed [XY_W-1:0]  r_x, r_y;
    logic signed [Z_W-1:0]   r_z;
    logic                    r_neg;

    logic [TURN_W-1:0]       w_quarter_test;
    logic                    w_neg;
    logic [TURN_W-1:0]       w_theta_red;
    logic signed [XY_W-1:0]  w_dx, w_dy, w_x_nxt, w_y_nxt;
    logic signed [Z_W-1:0]   w_atan, w_z_nxt;
    logic signed [XY_W-1:0]  w_y_sgn;
    logic signed [RND_W-1:0] w_sum, w_rnd, w_clamp;

    // Fold the angle into [-1/4, 1/4) turn, remember to negate
    always_comb begin
        w_quarter_test = i_theta + 32'h40000000;
        w_neg          = w_quarter_test[TURN_W-1];
        w_theta_red    = w_neg ? {~i_theta[TURN_W-1], i_theta[TURN_W-2:0]} : i_theta;
    end

    // Shared shift and add-subtract unit, one micro-rotation
    always_comb begin
        w_dx   = r_y >>> r_cnt;
        w_dy   = r_x >>> r_cnt;
        w_atan = $signed({1'b0, atan_turn(r_cnt)});
        if (!r_z[Z_W-1]) begin
            w_x_nxt = r_x - w_dx;
            w_y_nxt = r_y + w_dy;
            w_z_nxt = r_z - w_atan;
        end else begin
            w_x_nxt = r_x + w_dx;
            w_y_nxt = r_y - w_dy;
            w_z_nxt = r_z + w_atan;
        end
    end

    // Round half up to the output grid and clamp symmetric
    always_comb begin
        w_y_sgn = r_neg ? -r_y : r_y;
        w_sum   = {w_y_sgn[XY_W-1], w_y_sgn} + HALF;
        w_rnd   = w_sum >>> RND_SH;
        if (w_rnd > LIM)
            w_clamp = LIM;
        else if (w_rnd < NEG_LIM)
            w_clamp = NEG_LIM;
        else
            w_clamp = w_rnd;
    end

    // Sequence: load, iterate, hold result until taken
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_start) n_state = S_RUN;
            S_RUN:   if (r_cnt == LAST) n_state = S_DONE;
            S_DONE:  if (i_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_x   <= GAIN_Q30;
            r_y   <= '0;
            r_z   <= $signed({w_theta_red[TURN_W-1], w_theta_red});
            r_neg <= w_neg;
            r_cnt <= '0;
        end else if (r_state == S_RUN) begin
            r_x   <= w_x_nxt;
            r_y   <= w_y_nxt;
            r_z   <= w_z_nxt;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_stat.ready = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_sample     = w_clamp[OUT_BITS-1:0];

endmodule

/* design/phase_accumulator_sine_oscillator.sv */
// Top level: phase accumulator, output register and the CORDIC sine core.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------
//  input   | i_in_valid  | o_in_stall  | i_freq_step [31:0]
//  output  | o_out_valid | i_out_stall | o_sine_out [OUT_BITS-1:0]
//
// Each request passes through the core in steps: it loads the angle, runs
// min(CORDIC_STEPS, 24) micro-rotations, one per cycle, on the shared
// shift/add unit, and its rounded sample is loaded into the output register.
// Synchronous active-low reset clears the phase and all valid/state flags.
// The output register lets the core take the next request while a sample
// waits; a finished sample holds in the core while the output stays stalled.
module phase_accumulator_sine_oscillator
    import nco_pkg::*;
#(
    parameter int PHASE_BITS   = PHASE_BITS_DEF,
    parameter int OUT_BITS     = OUT_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [FREQ_W-1:0]          i_freq_step,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_BITS-1:0] o_sine_out
);

    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      w_step, w_phase_nxt;
    logic [TURN_W-1:0]          w_turn;
    logic                       r_out_valid;
    logic signed [OUT_BITS-1:0] r_sine;
    logic                       w_accept, w_take;
    t_core_stat                 w_stat;
    logic signed [OUT_BITS-1:0] w_sample;

    // Align the increment to the phase width, pick the top turn bits
    generate
        if (PHASE_BITS > FREQ_W) begin : g_wide
            assign w_step = {i_freq_step, {(PHASE_BITS - FREQ_W){1'b0}}};
            assign w_turn = w_phase_nxt[PHASE_BITS-1 -: TURN_W];
        end else if (PHASE_BITS == FREQ_W) begin : g_equal
            assign w_step = i_freq_step;
            assign w_turn = w_phase_nxt;
        end else begin : g_narrow
            assign w_step = i_freq_step[FREQ_W-1 -: PHASE_BITS];
            assign w_turn = {w_phase_nxt, {(TURN_W - PHASE_BITS){1'b0}}};
        end
    endgenerate

    assign w_phase_nxt = r_phase + w_step;
    assign w_accept    = i_in_valid && w_stat.ready;
    assign w_take      = w_stat.done && (!r_out_valid || !i_out_stall);

    // Advance the phase on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            r_phase <= w_phase_nxt;
        end
    end

    // Output register: load a finished sample, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sine <= w_sample;
        end
    end

    nco_cordic #(
        .OUT_BITS     (OUT_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_theta  (w_turn),
        .i_take   (w_take),
        .o_stat   (w_stat),
        .o_sample (w_sample)
    );

    assign o_in_stall  = !w_stat.ready;
    assign o_out_valid = r_out_valid;
    assign o_sine_out  = r_sine;

endmodule
